// File: rtl/cdm_pkg.sv
// Shared types and constants for the capped distance map.
`timescale 1ns / 1ps

package cdm_pkg;

  // Signed width for a coordinate plus a diamond offset
  localparam int CW = 9;

  // Width of the microcode step counter
  localparam int STEP_W = 5;

  // Operation codes of an input transaction
  localparam logic OP_MARK = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Fixed program addresses
  localparam logic [STEP_W-1:0] STEP_CLEAR   = 5'd0;
  localparam logic [STEP_W-1:0] STEP_IDLE    = 5'd1;
  localparam logic [STEP_W-1:0] STEP_DIAMOND = 5'd2;
  localparam logic [STEP_W-1:0] STEP_LAST    = 5'd26;
  localparam logic [STEP_W-1:0] STEP_READ    = 5'd27;
  localparam logic [STEP_W-1:0] STEP_RESULT  = 5'd28;

  // Micro-operation kinds
  typedef enum logic [2:0] {
    UOP_CLEAR,
    UOP_IDLE,
    UOP_VISIT,
    UOP_READ,
    UOP_RESULT
  } uop_e;

  // One microcode word
  typedef struct packed {
    uop_e                    uop;
    logic signed [2:0]       dr;
    logic signed [2:0]       dc;
    logic [2:0]              code;
    logic [STEP_W-1:0]       nxt;
    logic [STEP_W-1:0]       alt;
  } uword_t;

  // Sequencer to datapath control
  typedef struct packed {
    uop_e              uop;
    logic signed [2:0] dr;
    logic signed [2:0] dc;
    logic [2:0]        code;
    logic              load;
  } ctrl_t;

  // Datapath to sequencer status
  typedef struct packed {
    logic clr_last;
    logic src_ok;
  } stat_t;

endpackage

// File: rtl/cdm_ucode_rom.sv
// Microcode program store: one control word per sequencer step.
`timescale 1ns / 1ps

module cdm_ucode_rom
  import cdm_pkg::*;
(
  input  logic [STEP_W-1:0] step_i,
  output uword_t            word_o
);

  // Build a diamond visit word; the code is the Manhattan distance plus one
  function automatic uword_t visit(input logic signed [2:0] dr,
                                   input logic signed [2:0] dc,
                                   input logic [STEP_W-1:0] nxt);
    uword_t w;
    logic [2:0] adr;
    logic [2:0] adc;
    adr    = (dr < 0) ? 3'(-dr) : 3'(dr);
    adc    = (dc < 0) ? 3'(-dc) : 3'(dc);
    w.uop  = UOP_VISIT;
    w.dr   = dr;
    w.dc   = dc;
    w.code = adr + adc + 3'd1;
    w.nxt  = nxt;
    w.alt  = STEP_IDLE;
    return w;
  endfunction

  // Build a control word that carries no offsets
  function automatic uword_t plain(input uop_e uop,
                                   input logic [STEP_W-1:0] nxt,
                                   input logic [STEP_W-1:0] alt);
    uword_t w;
    w.uop  = uop;
    w.dr   = 3'sd0;
    w.dc   = 3'sd0;
    w.code = 3'd0;
    w.nxt  = nxt;
    w.alt  = alt;
    return w;
  endfunction

  // Program: clear sweep, dispatch, 25 diamond cells, read, result
  always_comb begin
    unique case (step_i)
      5'd0:  word_o = plain(UOP_CLEAR, STEP_IDLE, STEP_CLEAR);
      5'd1:  word_o = plain(UOP_IDLE, STEP_DIAMOND, STEP_READ);
      5'd2:  word_o = visit(-3'sd3,  3'sd0, 5'd3);
      5'd3:  word_o = visit(-3'sd2, -3'sd1, 5'd4);
      5'd4:  word_o = visit(-3'sd2,  3'sd0, 5'd5);
      5'd5:  word_o = visit(-3'sd2,  3'sd1, 5'd6);
      5'd6:  word_o = visit(-3'sd1, -3'sd2, 5'd7);
      5'd7:  word_o = visit(-3'sd1, -3'sd1, 5'd8);
      5'd8:  word_o = visit(-3'sd1,  3'sd0, 5'd9);
      5'd9:  word_o = visit(-3'sd1,  3'sd1, 5'd10);
      5'd10: word_o = visit(-3'sd1,  3'sd2, 5'd11);
      5'd11: word_o = visit( 3'sd0, -3'sd3, 5'd12);
      5'd12: word_o = visit( 3'sd0, -3'sd2, 5'd13);
      5'd13: word_o = visit( 3'sd0, -3'sd1, 5'd14);
      5'd14: word_o = visit( 3'sd0,  3'sd0, 5'd15);
      5'd15: word_o = visit( 3'sd0,  3'sd1, 5'd16);
      5'd16: word_o = visit( 3'sd0,  3'sd2, 5'd17);
      5'd17: word_o = visit( 3'sd0,  3'sd3, 5'd18);
      5'd18: word_o = visit( 3'sd1, -3'sd2, 5'd19);
      5'd19: word_o = visit( 3'sd1, -3'sd1, 5'd20);
      5'd20: word_o = visit( 3'sd1,  3'sd0, 5'd21);
      5'd21: word_o = visit( 3'sd1,  3'sd1, 5'd22);
      5'd22: word_o = visit( 3'sd1,  3'sd2, 5'd23);
      5'd23: word_o = visit( 3'sd2, -3'sd1, 5'd24);
      5'd24: word_o = visit( 3'sd2,  3'sd0, 5'd25);
      5'd25: word_o = visit( 3'sd2,  3'sd1, STEP_LAST);
      5'd26: word_o = visit( 3'sd3,  3'sd0, STEP_IDLE);
      5'd27: word_o = plain(UOP_READ, STEP_RESULT, STEP_IDLE);
      5'd28: word_o = plain(UOP_RESULT, STEP_IDLE, STEP_IDLE);
      // Unused addresses behave as the dispatch step
      default: word_o = plain(UOP_IDLE, STEP_DIAMOND, STEP_READ);
    endcase
  end

endmodule

// File: rtl/cdm_sequencer.sv
// Step counter and jump logic that walks the microcode program.
`timescale 1ns / 1ps

module cdm_sequencer
  import cdm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  input  logic  op_i,
  input  stat_t stat_i,
  output logic  busy,
  output logic  out_valid_o,
  output ctrl_t ctrl_o
);

  logic [STEP_W-1:0] step_q;
  logic [STEP_W-1:0] step_d;
  uword_t            word;
  logic              accept;

  cdm_ucode_rom u_rom (
    .step_i (step_q),
    .word_o (word)
  );

  assign accept = start && (word.uop == UOP_IDLE);

  // Next step: sequential flow with conditional jumps
  always_comb begin
    unique case (word.uop)
      UOP_CLEAR: step_d = stat_i.clr_last ? word.nxt : step_q;
      UOP_IDLE: begin
        priority if (!accept)         step_d = step_q;
        else if (op_i == OP_READ)     step_d = word.alt;
        else if (stat_i.src_ok)       step_d = word.nxt;
        else                          step_d = step_q;
      end
      default:   step_d = word.nxt;
    endcase
  end

  // Outputs decoded from the current control word
  always_comb begin
    busy         = (word.uop != UOP_IDLE);
    out_valid_o  = (word.uop == UOP_RESULT);
    ctrl_o.uop   = word.uop;
    ctrl_o.dr    = word.dr;
    ctrl_o.dc    = word.dc;
    ctrl_o.code  = word.code;
    ctrl_o.load  = accept;
  end

  // Hold the step counter; reset enters the clear sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_CLEAR;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// File: rtl/cdm_datapath.sv
// Grid memory, coordinate arithmetic, update compare and result path.
`timescale 1ns / 1ps

module cdm_datapath
  import cdm_pkg::*;
#(
  parameter int MAX_SIDE = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_t      ctrl_i,
  input  logic [6:0] row_i,
  input  logic [6:0] col_i,
  input  logic       cfg_valid_i,
  input  logic [6:0] cfg_data_i,
  output stat_t      stat_o,
  output logic [2:0] cell_value_o
);

  localparam int RW    = $clog2(MAX_SIDE);
  localparam int AW    = 2 * RW;
  localparam int DEPTH = 1 << AW;
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int CMPW  = (SW > 7) ? SW : 7;

  logic [6:0]           side_q;
  logic [6:0]           side_use;
  logic [6:0]           row_q;
  logic [6:0]           col_q;
  logic signed [CW-1:0] rr;
  logic signed [CW-1:0] cc;
  logic signed [CW-1:0] rm1;
  logic signed [CW-1:0] cm1;
  logic                 cell_ok;
  logic [AW-1:0]        raddr;
  logic [AW-1:0]        clr_cnt_q;
  logic                 pend_q;
  logic [AW-1:0]        pend_addr_q;
  logic [2:0]           pend_code_q;
  logic                 rd_ok_q;
  logic [2:0]           rdata_q;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [2:0]           wdata;
  logic [2:0]           mem [DEPTH];

  // Cell lies inside the grid in use
  function automatic logic in_grid(input logic signed [CW-1:0] r,
                                   input logic signed [CW-1:0] c,
                                   input logic [6:0] side);
    logic signed [CW-1:0] s;
    s = $signed(CW'(side));
    return (r >= 1) && (c >= 1) && (r <= s) && (c <= s);
  endfunction

  // Clamp the configured side to the physical grid
  always_comb begin
    if (CMPW'(side_q) > CMPW'(MAX_SIDE)) begin
      side_use = 7'(MAX_SIDE);
    end else begin
      side_use = side_q;
    end
  end

  // Source check on the incoming transaction
  assign stat_o.src_ok   = in_grid($signed(CW'(row_i)), $signed(CW'(col_i)), side_use);
  assign stat_o.clr_last = &clr_cnt_q;

  // Target cell of the current step
  assign rr      = $signed(CW'(row_q)) + CW'(ctrl_i.dr);
  assign cc      = $signed(CW'(col_q)) + CW'(ctrl_i.dc);
  assign rm1     = rr - CW'(1);
  assign cm1     = cc - CW'(1);
  assign cell_ok = in_grid(rr, cc, side_use);
  assign raddr   = {RW'($unsigned(rm1)), RW'($unsigned(cm1))};

  // Write port: clear sweep or the pending update of the previous visit
  always_comb begin
    if (ctrl_i.uop == UOP_CLEAR) begin
      we    = 1'b1;
      waddr = clr_cnt_q;
      wdata = 3'd0;
    end else begin
      we    = pend_q && ((rdata_q == 3'd0) || (rdata_q > pend_code_q));
      waddr = pend_addr_q;
      wdata = pend_code_q;
    end
  end

  // Drive the result from the registered read
  assign cell_value_o = rd_ok_q ? rdata_q : 3'd0;

  // Grid memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // Latch coordinates and the pending update payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      row_q <= row_i;
      col_q <= col_i;
    end
    pend_addr_q <= raddr;
    pend_code_q <= ctrl_i.code;
  end

  // Control state: side register, clear counter, pending and read flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q    <= 7'd64;
      clr_cnt_q <= '0;
      pend_q    <= 1'b0;
      rd_ok_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        side_q <= cfg_data_i;
      end
      if (ctrl_i.uop == UOP_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      pend_q <= (ctrl_i.uop == UOP_VISIT) && cell_ok;
      if (ctrl_i.uop == UOP_READ) begin
        rd_ok_q <= cell_ok;
      end
    end
  end

endmodule

// File: rtl/capped_distance_map.sv
// Top level of the capped distance map: sequencer plus grid datapath.
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+-----------------------------
//   command   | start in, busy out        | op_i, row_i, col_i
//   result    | out_valid_o strobe        | cell_value_o
//   config    | cfg_valid_i, cfg_ready_o  | cfg_data_i (grid_size)
//
// A mark transaction runs from the accept step through the diamond steps, one
// diamond cell per cycle, each a read of the grid memory followed by a
// compare-and-write of the same cell in the next cycle. A read transaction runs
// from the accept step through the read step to the result step, where the
// result strobes. After reset the grid memory is swept to zero, one cell a
// cycle, over 4**ceil(log2(MAX_SIDE)) cells (4096 by default), busy high;
// config writes always taken; receiver cannot stall, results never held.
`timescale 1ns / 1ps

module capped_distance_map
  import cdm_pkg::*;
#(
  parameter int MAX_SIDE = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       op_i,
  input  logic [6:0] row_i,
  input  logic [6:0] col_i,
  output logic       out_valid_o,
  output logic [2:0] cell_value_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] cfg_data_i
);

  ctrl_t ctrl;
  stat_t stat;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  cdm_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .op_i        (op_i),
    .stat_i      (stat),
    .busy        (busy),
    .out_valid_o (out_valid_o),
    .ctrl_o      (ctrl)
  );

  cdm_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .row_i        (row_i),
    .col_i        (col_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .stat_o       (stat),
    .cell_value_o (cell_value_o)
  );

endmodule
